// ----- hw/rtl/uqp_pkg.sv -----
// shared types, codes and helpers for the uri query parser
package uqp_pkg;

  // raw characters the parser reacts to
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // result kinds
  localparam logic [2:0] KIND_PATH    = 3'd0;
  localparam logic [2:0] KIND_NAME    = 3'd1;
  localparam logic [2:0] KIND_VALUE   = 3'd2;
  localparam logic [2:0] KIND_END_PAR = 3'd3;
  localparam logic [2:0] KIND_END_REQ = 3'd4;

  // escape progress
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_HIGH = 2'd1;
  localparam logic [1:0] ESC_LOW  = 2'd2;

  // results one input byte can cause
  localparam int unsigned NUM_SLOTS = 3;

  typedef enum logic [2:0] {
    PH_PATH  = 3'b001,
    PH_NAME  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       status;
  } result_t;

  // up to three results of one input byte, in delivery order
  typedef struct packed {
    logic [NUM_SLOTS-1:0]           valid;
    result_t [NUM_SLOTS-1:0]        slot;
  } bundle_t;

  // {is_hex, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/uqp_if.sv -----
// valid/ready channel interfaces for the uri query parser

// input byte channel
interface uqp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

// result channel
interface uqp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_status;
  logic       out_last;

  modport source (output valid, output out_kind, output out_byte, output out_status,
                  output out_last, input ready);
  modport sink (input valid, input out_kind, input out_byte, input out_status,
                input out_last, output ready);
endinterface

// ----- hw/rtl/uri_query_parser.sv -----
// top level of the streaming uri path and query parser
//
//   channel   dir   payload                                   transaction
//   in_ch     in    in_byte[7:0], in_last                     one uri byte
//   out_ch    out   out_kind[2:0], out_byte[7:0], out_status,  one result
//                   out_last
//
// a byte is decoded in the cycle it is accepted and its results land in the
// result register the next cycle; a new byte is taken every cycle while each
// byte causes at most one result and out_ch does not stall.
// the final byte of a uri can cause up to three results, which leave one per
// cycle while out_ch does not stall; the input waits until the last is taken.
// a stall on out_ch holds the result register and drops in_ch.ready once the
// remaining results would not drain this cycle.
// rst is synchronous and returns the parser to the start of a new uri.
module uri_query_parser
  import uqp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  uqp_in_if.sink    in_ch,
  uqp_out_if.source out_ch
);

  bundle_t bundle;
  result_t head;
  logic    can_load;
  logic    accept;
  logic    head_last;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid & can_load;

  uqp_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .bundle  (bundle)
  );

  uqp_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .bundle_in (bundle),
    .can_load  (can_load),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .head      (head),
    .head_last (head_last)
  );

  // result port
  assign out_ch.out_kind   = head.kind;
  assign out_ch.out_byte   = head.data;
  assign out_ch.out_status = head.status;
  assign out_ch.out_last   = head_last;

endmodule

// ----- hw/rtl/uqp_decode.sv -----
// parser state and per-byte decode into a bundle of up to three results
module uqp_decode
  import uqp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output bundle_t    bundle
);

  phase_t     phase, phase_next;
  logic [1:0] escape_step, escape_step_next;
  logic [3:0] high_nibble, high_nibble_next;
  logic       path_started, path_started_next;
  logic       prev_was_dot, prev_was_dot_next;
  logic       path_bad, path_bad_next;
  logic       value_dropped, value_dropped_next;
  logic       segment_nonempty, segment_nonempty_next;

  logic [4:0] hex;
  logic       handled;
  logic       path_emit;
  logic [7:0] path_data;
  logic       req_bad;

  assign hex = hex_decode(in_byte);

  // next state and results for the byte at the input
  always_comb begin
    phase_next            = phase;
    escape_step_next      = escape_step;
    high_nibble_next      = high_nibble;
    path_started_next     = path_started;
    prev_was_dot_next     = prev_was_dot;
    path_bad_next         = path_bad;
    value_dropped_next    = value_dropped;
    segment_nonempty_next = segment_nonempty;
    handled   = 1'b0;
    path_emit = 1'b0;
    path_data = in_byte;
    req_bad   = 1'b0;
    bundle    = '0;

    unique case (phase)
      PH_PATH: begin
        // escape digits
        if (escape_step != ESC_NONE) begin
          if (hex[4]) begin
            handled = 1'b1;
            if (escape_step == ESC_HIGH) begin
              high_nibble_next = hex[3:0];
              escape_step_next = ESC_LOW;
            end else begin
              path_emit        = 1'b1;
              path_data        = {high_nibble, hex[3:0]};
              escape_step_next = ESC_NONE;
              high_nibble_next = 4'd0;
            end
          end else begin
            path_bad_next    = 1'b1;
            escape_step_next = ESC_NONE;
            high_nibble_next = 4'd0;
          end
        end
        // ordinary path byte
        if (!handled) begin
          if (in_byte == CH_PCT) begin
            escape_step_next = ESC_HIGH;
          end else if (in_byte == CH_PLUS) begin
            path_emit = 1'b1;
            path_data = CH_SPACE;
          end else if (in_byte == CH_QMARK) begin
            phase_next            = PH_NAME;
            segment_nonempty_next = 1'b0;
            value_dropped_next    = 1'b0;
          end else begin
            path_emit = 1'b1;
          end
        end
        // path checks on the decoded byte
        if (path_emit) begin
          if (!path_started) begin
            path_started_next = 1'b1;
            if (path_data != CH_SLASH) path_bad_next = 1'b1;
          end
          if (path_data == CH_DOT && prev_was_dot) path_bad_next = 1'b1;
          prev_was_dot_next = (path_data == CH_DOT);
          bundle.valid[0]   = 1'b1;
          bundle.slot[0]    = '{kind: KIND_PATH, data: path_data, status: 1'b0};
        end
      end
      PH_NAME: begin
        if (in_byte == CH_AMP) begin
          bundle.valid[0]       = segment_nonempty;
          bundle.slot[0]        = '{kind: KIND_END_PAR, data: 8'd0, status: 1'b0};
          segment_nonempty_next = 1'b0;
          escape_step_next      = ESC_NONE;
          high_nibble_next      = 4'd0;
          value_dropped_next    = 1'b0;
        end else if (in_byte == CH_EQ) begin
          segment_nonempty_next = 1'b1;
          phase_next            = PH_VALUE;
          value_dropped_next    = 1'b0;
          escape_step_next      = ESC_NONE;
          high_nibble_next      = 4'd0;
        end else begin
          segment_nonempty_next = 1'b1;
          bundle.valid[0]       = 1'b1;
          bundle.slot[0]        = '{kind: KIND_NAME, data: in_byte, status: 1'b0};
        end
      end
      PH_VALUE: begin
        if (in_byte == CH_AMP) begin
          bundle.valid[0]       = segment_nonempty;
          bundle.slot[0]        = '{kind: KIND_END_PAR, data: 8'd0, status: 1'b0};
          segment_nonempty_next = 1'b0;
          phase_next            = PH_NAME;
          escape_step_next      = ESC_NONE;
          high_nibble_next      = 4'd0;
          value_dropped_next    = 1'b0;
        end else if (value_dropped) begin
          // rest of a broken value is dropped
        end else if (escape_step != ESC_NONE) begin
          if (!hex[4]) begin
            value_dropped_next = 1'b1;
            escape_step_next   = ESC_NONE;
            high_nibble_next   = 4'd0;
          end else if (escape_step == ESC_HIGH) begin
            high_nibble_next = hex[3:0];
            escape_step_next = ESC_LOW;
          end else begin
            bundle.valid[0]  = 1'b1;
            bundle.slot[0]   = '{kind: KIND_VALUE, data: {high_nibble, hex[3:0]},
                                 status: 1'b0};
            escape_step_next = ESC_NONE;
            high_nibble_next = 4'd0;
          end
        end else if (in_byte == CH_PCT) begin
          escape_step_next = ESC_HIGH;
        end else begin
          bundle.valid[0] = 1'b1;
          bundle.slot[0]  = '{kind: KIND_VALUE,
                              data: (in_byte == CH_PLUS) ? CH_SPACE : in_byte,
                              status: 1'b0};
        end
      end
      default: begin
        phase_next = PH_PATH;
      end
    endcase

    // close the request on the final byte
    if (in_last) begin
      req_bad = path_bad_next | ~path_started_next |
                (phase_next == PH_PATH && escape_step_next != ESC_NONE);
      bundle.valid[1] = (phase_next != PH_PATH) && segment_nonempty_next;
      bundle.slot[1]  = '{kind: KIND_END_PAR, data: 8'd0, status: 1'b0};
      bundle.valid[2] = 1'b1;
      bundle.slot[2]  = '{kind: KIND_END_REQ, data: 8'd0, status: req_bad};
      phase_next            = PH_PATH;
      escape_step_next      = ESC_NONE;
      high_nibble_next      = 4'd0;
      path_started_next     = 1'b0;
      prev_was_dot_next     = 1'b0;
      path_bad_next         = 1'b0;
      value_dropped_next    = 1'b0;
      segment_nonempty_next = 1'b0;
    end
  end

  // state update on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_PATH;
      escape_step      <= ESC_NONE;
      high_nibble      <= 4'd0;
      path_started     <= 1'b0;
      prev_was_dot     <= 1'b0;
      path_bad         <= 1'b0;
      value_dropped    <= 1'b0;
      segment_nonempty <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      escape_step      <= escape_step_next;
      high_nibble      <= high_nibble_next;
      path_started     <= path_started_next;
      prev_was_dot     <= prev_was_dot_next;
      path_bad         <= path_bad_next;
      value_dropped    <= value_dropped_next;
      segment_nonempty <= segment_nonempty_next;
    end
  end

endmodule

// ----- hw/rtl/uqp_out_queue.sv -----
// result register holding one bundle and sending its results one per cycle while out_ready is high
module uqp_out_queue
  import uqp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  bundle_t bundle_in,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t head,
  output logic    head_last
);

  logic [NUM_SLOTS-1:0] mask, mask_next;
  result_t [NUM_SLOTS-1:0] slot;
  logic [NUM_SLOTS-1:0] head_sel;
  logic fire;

  // lowest pending slot goes first
  always_comb begin
    head_sel = '0;
    head     = slot[0];
    if (mask[0]) begin
      head_sel = 3'b001;
      head     = slot[0];
    end else if (mask[1]) begin
      head_sel = 3'b010;
      head     = slot[1];
    end else if (mask[2]) begin
      head_sel = 3'b100;
      head     = slot[2];
    end
  end

  assign out_valid = |mask;
  assign fire      = out_valid & out_ready;
  assign mask_next = fire ? (mask & ~head_sel) : mask;
  assign head_last = ((mask & ~head_sel) == '0);
  assign can_load  = (mask_next == '0);

  // pending mask
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= bundle_in.valid;
    end else begin
      mask <= mask_next;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      slot <= bundle_in.slot;
    end
  end

endmodule

// ----- hw/rtl/uqp_checker.sv -----
// port-level checks for the uri query parser, bound to the top level
module uqp_checker
  import uqp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_kind,
  input logic [7:0] out_byte,
  input logic       out_status,
  input logic       out_last
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_kind) && $stable(out_byte) &&
      $stable(out_status) && $stable(out_last))
    else $error("result payload changed while stalled");

  // end of request closes the results of its byte
  a_end_req_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == KIND_END_REQ |-> out_last)
    else $error("end of request not marked last");

  // status only on end of request, no byte on end of parameter
  a_fields_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_END_REQ |-> !out_status &&
      (out_kind != KIND_END_PAR || out_byte == 8'd0))
    else $error("stray status or byte on result");

endmodule

bind uri_query_parser uqp_checker u_uqp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.out_kind),
  .out_byte   (out_ch.out_byte),
  .out_status (out_ch.out_status),
  .out_last   (out_ch.out_last)
);

// ----- dv/testbench.sv -----
// self-checking testbench for the uri query parser: directed and random uris
module testbench;
  import uqp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       status;
    logic       last;
  } parse_result_t;

  logic clk;
  logic rst;

  uqp_in_if  in_ch ();
  uqp_out_if out_ch ();

  uri_query_parser DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // parser state mirror
  phase_t      uri_phase;
  logic [1:0]  esc_step;
  logic [3:0]  esc_high;
  logic        path_started;
  logic        last_dot;
  logic        path_bad;
  logic        value_dropped;
  logic        seg_nonempty;

  parse_result_t pending_results[$];
  parse_result_t byte_results[$];
  logic [7:0]    uri_bytes[$];

  int unsigned cycle_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned fail_count = 0;
  int unsigned stall_left = 0;
  bit          idle_on = 1'b1;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // random gap length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int hex_nibble(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - 48;
    if (c >= "a" && c <= "f") return int'(c) - 87;
    if (c >= "A" && c <= "F") return int'(c) - 55;
    return -1;
  endfunction

  // predictor
  task automatic reset_parser_state();
    uri_phase     = PH_PATH;
    esc_step      = ESC_NONE;
    esc_high      = 4'd0;
    path_started  = 1'b0;
    last_dot      = 1'b0;
    path_bad      = 1'b0;
    value_dropped = 1'b0;
    seg_nonempty  = 1'b0;
  endtask

  task automatic add_result(input logic [2:0] kind, input logic [7:0] data, input logic status);
    parse_result_t r;
    r.kind   = kind;
    r.data   = data;
    r.status = status;
    r.last   = 1'b0;
    byte_results.insert(byte_results.size(), r);
  endtask

  task automatic emit_path_byte(input logic [7:0] b);
    if (!path_started) begin
      path_started = 1'b1;
      if (b != CH_SLASH) path_bad = 1'b1;
    end
    if (b == CH_DOT && last_dot) path_bad = 1'b1;
    last_dot = (b == CH_DOT);
    add_result(KIND_PATH, b, 1'b0);
  endtask

  task automatic close_segment();
    if (seg_nonempty) add_result(KIND_END_PAR, 8'd0, 1'b0);
    seg_nonempty  = 1'b0;
    uri_phase     = PH_NAME;
    esc_step      = ESC_NONE;
    esc_high      = 4'd0;
    value_dropped = 1'b0;
  endtask

  task automatic decode_path_char(input logic [7:0] c);
    int h;
    h = hex_nibble(c);
    // pending escape: hex digit continues it, anything else cancels it
    if (esc_step != ESC_NONE) begin
      if (h >= 0) begin
        if (esc_step == ESC_HIGH) begin
          esc_high = h[3:0];
          esc_step = ESC_LOW;
        end else begin
          emit_path_byte({esc_high, h[3:0]});
          esc_step = ESC_NONE;
          esc_high = 4'd0;
        end
        return;
      end
      path_bad = 1'b1;
      esc_step = ESC_NONE;
      esc_high = 4'd0;
    end
    if (c == CH_PCT) begin
      esc_step = ESC_HIGH;
    end else if (c == CH_PLUS) begin
      emit_path_byte(CH_SPACE);
    end else if (c == CH_QMARK) begin
      uri_phase     = PH_NAME;
      seg_nonempty  = 1'b0;
      value_dropped = 1'b0;
    end else begin
      emit_path_byte(c);
    end
  endtask

  task automatic decode_value_char(input logic [7:0] c);
    int h;
    h = hex_nibble(c);
    if (c == CH_AMP) begin
      close_segment();
      return;
    end
    if (value_dropped) return;
    // bad escape drops the rest of the value
    if (esc_step != ESC_NONE) begin
      if (h < 0) begin
        value_dropped = 1'b1;
        esc_step      = ESC_NONE;
        esc_high      = 4'd0;
      end else if (esc_step == ESC_HIGH) begin
        esc_high = h[3:0];
        esc_step = ESC_LOW;
      end else begin
        add_result(KIND_VALUE, {esc_high, h[3:0]}, 1'b0);
        esc_step = ESC_NONE;
        esc_high = 4'd0;
      end
      return;
    end
    if (c == CH_PCT) esc_step = ESC_HIGH;
    else if (c == CH_PLUS) add_result(KIND_VALUE, CH_SPACE, 1'b0);
    else add_result(KIND_VALUE, c, 1'b0);
  endtask

  task automatic predict_uri_byte(input logic [7:0] c, input logic is_last);
    logic          bad;
    parse_result_t r;
    byte_results.delete();
    case (uri_phase)
      PH_PATH: begin
        decode_path_char(c);
      end
      PH_NAME: begin
        if (c == CH_AMP) begin
          close_segment();
        end else if (c == CH_EQ) begin
          seg_nonempty  = 1'b1;
          uri_phase     = PH_VALUE;
          value_dropped = 1'b0;
          esc_step      = ESC_NONE;
          esc_high      = 4'd0;
        end else begin
          seg_nonempty = 1'b1;
          add_result(KIND_NAME, c, 1'b0);
        end
      end
      default: begin
        decode_value_char(c);
      end
    endcase
    // final byte closes the open parameter and reports the path status
    if (is_last) begin
      bad = path_bad || !path_started || (uri_phase == PH_PATH && esc_step != ESC_NONE);
      if (uri_phase != PH_PATH && seg_nonempty) add_result(KIND_END_PAR, 8'd0, 1'b0);
      add_result(KIND_END_REQ, 8'd0, bad);
      reset_parser_state();
    end
    foreach (byte_results[i]) begin
      r = byte_results[i];
      r.last = (i == byte_results.size() - 1);
      pending_results.insert(pending_results.size(), r);
    end
  endtask

  // input side: one transaction per byte
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    @(negedge clk);
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= is_last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_uri_byte(b, is_last);
    bytes_sent++;
  endtask

  task automatic send_uri();
    foreach (uri_bytes[i]) send_byte(uri_bytes[i], i == uri_bytes.size() - 1);
  endtask

  // append one byte to the uri under construction
  task automatic append_byte(input logic [7:0] b);
    uri_bytes.insert(uri_bytes.size(), b);
  endtask

  task automatic load_string(input string s);
    for (int i = 0; i < s.len(); i++) append_byte(s[i]);
  endtask

  // random uri pieces
  function automatic logic [7:0] hex_char(input int unsigned n);
    logic [7:0] base;
    if (n < 10) return 8'h30 + 8'(n);
    base = ($urandom_range(0, 1) != 0) ? "a" : "A";
    return base + 8'(n - 10);
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (hex_nibble(b) >= 0);
    return b;
  endfunction

  task automatic add_escape(input bit good);
    append_byte(CH_PCT);
    if (good) begin
      append_byte(hex_char($urandom_range(0, 15)));
      append_byte(hex_char($urandom_range(0, 15)));
    end else begin
      if ($urandom_range(0, 1) != 0) append_byte(hex_char($urandom_range(0, 15)));
      append_byte(non_hex_char());
    end
  endtask

  // one path or value token; dots and slashes only make sense in the path
  task automatic add_text_token(input bit in_path);
    int unsigned r;
    r = $urandom_range(0, 11);
    case (r) inside
      [0:3]:   append_byte(8'($urandom_range(0, 255)));
      4:       append_byte("a" + 8'($urandom_range(0, 25)));
      5:       append_byte(in_path ? CH_DOT : "x");
      6:       append_byte(in_path ? CH_SLASH : CH_EQ);
      7:       append_byte(CH_PLUS);
      [8:9]:   add_escape(1'b1);
      10:      add_escape($urandom_range(0, 3) != 0);
      default: add_escape(1'b0);
    endcase
  endtask

  task automatic add_name_byte();
    case ($urandom_range(0, 5))
      0:       append_byte(CH_PCT);
      1:       append_byte(CH_PLUS);
      2:       append_byte(CH_QMARK);
      3:       append_byte(8'($urandom_range(0, 255)));
      default: append_byte("a" + 8'($urandom_range(0, 25)));
    endcase
  endtask

  task automatic build_random_uri();
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    uri_bytes.delete();
    // noise: arbitrary bytes
    if ($urandom_range(0, 7) == 0) begin
      n = $urandom_range(1, 10);
      repeat (n) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 9) != 0) append_byte(CH_SLASH);
    n = $urandom_range(0, 6);
    repeat (n) add_text_token(1'b1);
    if ($urandom_range(0, 5) != 0) begin
      append_byte(CH_QMARK);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) begin
          append_byte(CH_AMP);
          if ($urandom_range(0, 4) == 0) append_byte(CH_AMP);
        end
        k = $urandom_range(0, 3);
        repeat (k) add_name_byte();
        if ($urandom_range(0, 3) != 0) begin
          append_byte(CH_EQ);
          k = $urandom_range(0, 4);
          repeat (k) add_text_token(1'b0);
        end
      end
      if ($urandom_range(0, 6) == 0) append_byte(CH_AMP);
    end
    if (uri_bytes.size() == 0) append_byte(CH_SLASH);
    // sometimes cut the uri short, leaving escapes open
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, uri_bytes.size());
      while (uri_bytes.size() > cut) void'(uri_bytes.pop_back());
    end
  endtask

  // tests
  task automatic test_directed();
    idle_on = 1'b1;
    // empty path
    uri_bytes.delete();
    load_string("?");
    send_uri();
    // first byte not a slash, then a double dot
    uri_bytes.delete();
    append_byte(8'hFF);
    load_string("..");
    send_uri();
    // escape still open at the final byte
    uri_bytes.delete();
    load_string("/%4");
    send_uri();
    // good request with a plus in the path
    uri_bytes.delete();
    load_string("/+");
    send_uri();
    // bad path escapes, query start inside an escape, dropped value,
    // empty segment, lone '=', raw name chars, decoded value ending in zero
    uri_bytes.delete();
    load_string("/%Z%?a=%z&&=&%+?=%41");
    append_byte(8'h00);
    send_uri();
  endtask

  task automatic test_random_back_to_back();
    idle_on = 1'b0;
    while (bytes_sent < 120) begin
      build_random_uri();
      send_uri();
    end
  endtask

  task automatic test_random_with_gaps();
    idle_on = 1'b1;
    while (bytes_sent < 255) begin
      build_random_uri();
      send_uri();
    end
  endtask

  // output side: random ready stalls
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // result check against the oldest expectation
  always @(posedge clk) begin
    parse_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d byte %02h status %0d last %0d", $time,
                 out_ch.out_kind, out_ch.out_byte, out_ch.out_status, out_ch.out_last);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.out_kind !== want.kind || out_ch.out_byte !== want.data ||
            out_ch.out_status !== want.status || out_ch.out_last !== want.last) begin
          $display("%0t: mismatch exp k%0d b%02h s%0d l%0d got k%0d b%02h s%0d l%0d",
                   $time, want.kind, want.data, want.status, want.last, out_ch.out_kind,
                   out_ch.out_byte, out_ch.out_status, out_ch.out_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout after %0d cycles", $time, cycle_count);
    $display("testbench: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.in_last = 1'b0;
    reset_parser_state();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_back_to_back();
    test_random_with_gaps();

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
